// ===== rtl/core/phx_pkg.sv =====
// ----------------------------------------------------------------------------
// phx_pkg
// Shared types and constants for the Philox 4x32 counter-based generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phx_pkg;

  // Round multipliers and Weyl key increments
  localparam logic [31:0] MUL_LANE0   = 32'hD2511F53;
  localparam logic [31:0] MUL_LANE2   = 32'hCD9E8D57;
  localparam logic [31:0] KEY_STEP0   = 32'h9E3779B9;
  localparam logic [31:0] KEY_STEP1   = 32'hBB67AE85;

  // Seed salts and the fixed revision word of the counter
  localparam logic [31:0] SEED_MIX_LO = 32'h55434F50;
  localparam logic [31:0] SEED_MIX_HI = 32'h52303133;
  localparam logic [31:0] REV_WORD    = 32'h20260823;

  // Configuration port geometry: one 64-bit register at byte address 8*i
  localparam int          ADDR_W      = 4;
  localparam logic [0:0]  REG_SEED    = 1'b0;

  typedef struct packed {
    logic [7:0]  stream_tag;
    logic [7:0]  panel_id;
    logic [7:0]  arm_id;
    logic [7:0]  network_id;
    logic [31:0] counter_a;
    logic [31:0] counter_b;
  } phx_in_t;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [23:0] uniform_fraction;
  } phx_out_t;

  // The four counter words as they travel down the round pipeline
  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
  } phx_state_t;

endpackage

// ===== rtl/core/phx_cfg.sv =====
// ----------------------------------------------------------------------------
// phx_cfg
// Configuration register file: holds the seed and derives the salted keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phx_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [phx_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  output logic [31:0]               key0,
  output logic [31:0]               key1
);
  import phx_pkg::*;

  logic [63:0] seed;
  logic        sel_seed;

  // Byte address 8*i selects register i; the low three bits are ignored.
  assign sel_seed = (paddr[ADDR_W-1:3] == REG_SEED);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (psel && penable && pwrite && pready && sel_seed) begin
      seed <= pwdata;
    end
  end

  assign prdata = sel_seed ? seed : '0;

  assign key0 = seed[31:0]  ^ SEED_MIX_LO;
  assign key1 = seed[63:32] ^ SEED_MIX_HI;

endmodule

// ===== rtl/core/phx_round.sv =====
// ----------------------------------------------------------------------------
// phx_round
// One Philox round as a registered pipeline stage with valid/ready flow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phx_round #(
  parameter int ROUND_IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  phx_pkg::phx_state_t in_state,
  input  logic [31:0]         key_base0,
  input  logic [31:0]         key_base1,
  output logic                out_valid,
  input  logic                out_ready,
  output phx_pkg::phx_state_t out_state
);
  import phx_pkg::*;

  // The key of round r is the salted seed plus r Weyl increments.
  localparam logic [63:0] OFS0_FULL = 64'(ROUND_IDX) * 64'(KEY_STEP0);
  localparam logic [63:0] OFS1_FULL = 64'(ROUND_IDX) * 64'(KEY_STEP1);
  localparam logic [31:0] KEY_OFS0  = OFS0_FULL[31:0];
  localparam logic [31:0] KEY_OFS1  = OFS1_FULL[31:0];

  logic [63:0] prod0;
  logic [63:0] prod2;
  logic [31:0] key0;
  logic [31:0] key1;
  phx_state_t  state_next;

  assign prod0 = 64'(in_state.x0) * 64'(MUL_LANE0);
  assign prod2 = 64'(in_state.x2) * 64'(MUL_LANE2);
  assign key0  = key_base0 + KEY_OFS0;
  assign key1  = key_base1 + KEY_OFS1;

  always_comb begin
    state_next.x0 = prod2[63:32] ^ in_state.x1 ^ key0;
    state_next.x1 = prod2[31:0];
    state_next.x2 = prod0[63:32] ^ in_state.x3 ^ key1;
    state_next.x3 = prod0[31:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_capture: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("stage dropped an accepted request");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_state)))
    else $error("stalled stage lost or changed its request");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("stage holds a request straight after reset");
`endif

endmodule

// ===== rtl/core/philox_counter_rng.sv =====
// ----------------------------------------------------------------------------
// philox_counter_rng
// Each round is its own registered pipeline stage with its own pair of 32x32
// multipliers; the chain of ROUNDS stages takes one request per cycle while the
// result channel is ready, and a stall on that channel holds the flow.
// Reset: synchronous, clears the seed to zero and empties every stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Counter-based Philox 4x32 generator.
//
// Each request carries two counter words and four identity bytes. The bytes
// are packed into counter word 2 (tag in the low byte, then panel, arm and
// network), and counter word 3 is the fixed revision word. The request then
// passes through ROUNDS identical stages, each of which performs one round:
// two full 32x32 products, the XOR mix with the round key and the lane
// permutation. The key of each stage is derived from the seed register plus
// a per-stage constant offset, so no key state travels with the data.
//
// Flow control is a simple ready chain: a stage takes a new request when it
// is empty or when its contents move on in the same cycle. A stalled result
// holds the last stage; the earlier stages keep filling and hold once full.
// The last stage register is the result register; the uniform fraction is
// the top 24 bits of word 0.
//
// The seed may only be rewritten while no request is in flight.

module philox_counter_rng #(
  parameter int ROUNDS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       item_valid,
  output logic                       item_ready,
  input  phx_pkg::phx_in_t           item,
  // result channel
  output logic                       result_valid,
  input  logic                       result_ready,
  output phx_pkg::phx_out_t          result,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [phx_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import phx_pkg::*;

  logic [31:0] key0;
  logic [31:0] key1;

  // Stage i reads vld/st at index i and drives rdy there; it drives vld/st at i+1 and reads rdy[i+1].
  logic       vld [ROUNDS+1];
  logic       rdy [ROUNDS+1];
  phx_state_t st  [ROUNDS+1];

  phx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key0    (key0),
    .key1    (key1)
  );

  // Build the 128-bit counter from the request.
  always_comb begin
    st[0].x0 = item.counter_a;
    st[0].x1 = item.counter_b;
    st[0].x2 = {item.network_id, item.arm_id, item.panel_id, item.stream_tag};
    st[0].x3 = REV_WORD;
  end

  assign vld[0]      = item_valid;
  assign item_ready  = rdy[0];
  assign rdy[ROUNDS] = result_ready;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    phx_round #(
      .ROUND_IDX (r)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[r]),
      .in_ready  (rdy[r]),
      .in_state  (st[r]),
      .key_base0 (key0),
      .key_base1 (key1),
      .out_valid (vld[r+1]),
      .out_ready (rdy[r+1]),
      .out_state (st[r+1])
    );
  end

  // The final stage register doubles as the result register.
  assign result_valid = vld[ROUNDS];

  always_comb begin
    result.word0            = st[ROUNDS].x0;
    result.word1            = st[ROUNDS].x1;
    result.word2            = st[ROUNDS].x2;
    result.word3            = st[ROUNDS].x3;
    result.uniform_fraction = st[ROUNDS].x0[31:8];
  end

endmodule
